// File: src/rtt_pkg.sv
package rtt_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   localparam logic [1:0] REQ_SEND = 2'd0;
   localparam logic [1:0] REQ_ACK  = 2'd1;
   localparam logic [1:0] REQ_TICK = 2'd2;
   localparam logic [1:0] REQ_NACK = 2'd3;

   localparam logic [3:0] ST_SENT      = 4'd0;
   localparam logic [3:0] ST_RETX      = 4'd1;
   localparam logic [3:0] ST_NONE_DUE  = 4'd2;
   localparam logic [3:0] ST_ACK_CLR   = 4'd3;
   localparam logic [3:0] ST_ACK_NOTUS = 4'd4;
   localparam logic [3:0] ST_ACK_UNK   = 4'd5;
   localparam logic [3:0] ST_HASH_MISS = 4'd6;
   localparam logic [3:0] ST_ZERO_ID   = 4'd7;
   localparam logic [3:0] ST_DUP       = 4'd8;
   localparam logic [3:0] ST_BAD_DEST  = 4'd9;
   localparam logic [3:0] ST_FULL      = 4'd10;
   localparam logic [3:0] ST_EXHAUST   = 4'd11;
   localparam logic [3:0] ST_NACK      = 4'd12;
   localparam logic [3:0] ST_NACK_NOTUS = 4'd13;

   localparam logic [1:0] CSR_SELF  = 2'd0;
   localparam logic [1:0] CSR_BASE  = 2'd1;
   localparam logic [1:0] CSR_MAX   = 2'd2;
   localparam logic [1:0] CSR_TRIES = 2'd3;

   typedef struct packed {
      logic [31:0] msg_id;
      logic        link;
      logic [9:0]  tries;
      logic [63:0] last_send;
      logic [63:0] hash_lo;
      logic [63:0] hash_hi;
   } entry_type;

   typedef struct packed {
      logic [1:0]  own_party;
      logic [15:0] base_timeout;
      logic [19:0] max_timeout;
      logic [9:0]  max_tries;
   } cfg_type;

endpackage

// File: src/rtt_entry_ram.sv
module rtt_entry_ram (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [rtt_pkg::IDX_W-1:0] wr_addr,
   input  rtt_pkg::entry_type        wr_data,
   input  logic [rtt_pkg::IDX_W-1:0] rd_addr,
   output rtt_pkg::entry_type        rd_data
);
   import rtt_pkg::*;

   entry_type mem [ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: src/rtt_timeout.sv
// Backed-off timeout, registered.
module rtt_timeout (
   input  logic        clock,
   input  logic [15:0] base_timeout,
   input  logic [19:0] max_timeout,
   input  logic [9:0]  tries,
   output logic [19:0] rto
);
   import rtt_pkg::*;

   logic [19:0] rto_ff;
   logic [19:0] rto_in;
   logic [50:0] shifted;

   always_comb begin
      shifted = {35'd0, base_timeout} << tries[4:0];
      if (tries >= 10'd31 || shifted > {31'd0, max_timeout}) begin
         rto_in = max_timeout;
      end else begin
         rto_in = shifted[19:0];
      end
   end

   always_ff @(posedge clock) begin
      rto_ff <= rto_in;
   end

   assign rto = rto_ff;
endmodule

// File: src/retransmit_timer_table.sv
// Send/ack: one RAM read per entry for the id search.
// Tick: each entry scanned is read, its timeout registered, then compared and written back;
// the scan stops early on exhaustion, and a stalled output holds it.
// Each tick result is held until the next due entry or the scan end, so it can carry last.
// Nack: no search. One transaction in flight; next accepted once the last result is taken.
// Reset (synchronous, active high) clears the valid bits, the FSM and restores register defaults.
module retransmit_timer_table (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [19:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // msg_id[31:0], dest[39:32], hash_lo[103:40], hash_hi[167:104], now_ms[231:168]
   input  logic [231:0] req_tdata,
   input  logic [1:0]   req_tuser,   // req_type
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[3:0], msg_id_res[35:4], link[36], zero fill to 40
   output logic [39:0]  rsp_tdata,
   output logic         rsp_tlast
);
   import rtt_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SRCH = 3'd1;
   localparam logic [2:0] S_DEC  = 3'd2;
   localparam logic [2:0] S_TRD  = 3'd3;
   localparam logic [2:0] S_TTO  = 3'd4;
   localparam logic [2:0] S_TCMP = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;
   localparam logic [2:0] S_TEND = 3'd7;

   cfg_type cfg_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{own_party: 2'd0, base_timeout: 16'd50, max_timeout: 20'd10000,
                     max_tries: 10'd400};
      end else if (csr_we) begin
         case (csr_index)
            CSR_SELF:  cfg_ff.own_party    <= csr_wdata[1:0];
            CSR_BASE:  cfg_ff.base_timeout <= csr_wdata[15:0];
            CSR_MAX:   cfg_ff.max_timeout  <= csr_wdata[19:0];
            CSR_TRIES: cfg_ff.max_tries    <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   logic [2:0]       state_ff;
   logic [1:0]       req_ff;
   logic [31:0]      id_ff;
   logic [7:0]       dst_ff;
   logic [63:0]      hlo_ff, hhi_ff, now_ff;
   logic [ENTRIES-1:0] valid_ff;
   logic [CNT_W-1:0] idx_ff;      // entry being read / scanned
   logic             found_ff;
   logic [IDX_W-1:0] found_idx_ff;
   logic             stop_ff;
   logic             rsp_valid_ff;
   logic [3:0]       rsp_status_ff;
   logic [31:0]      rsp_id_ff;
   logic             rsp_link_ff;
   logic             rsp_last_ff;
   // newest tick result, waiting until the scan knows whether it is the last
   logic             hold_ff;
   logic [3:0]       hold_status_ff;
   logic [31:0]      hold_id_ff;
   logic             hold_link_ff;

   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   entry_type        ram_wdata;
   logic [IDX_W-1:0] ram_raddr;
   entry_type        ram_rdata;
   logic [19:0]      rto;

   rtt_entry_ram u_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ram_wdata),
      .rd_addr(ram_raddr), .rd_data(ram_rdata)
   );

   rtt_timeout u_to (
      .clock(clock), .base_timeout(cfg_ff.base_timeout), .max_timeout(cfg_ff.max_timeout),
      .tries(ram_rdata.tries), .rto(rto)
   );

   logic [1:0] next_p, prev_p;
   always_comb begin
      case (cfg_ff.own_party)
         2'd1:    begin next_p = 2'd2; prev_p = 2'd0; end
         2'd2:    begin next_p = 2'd0; prev_p = 2'd1; end
         default: begin next_p = 2'd1; prev_p = 2'd2; end
      endcase
   end

   // lowest free entry
   logic             free_any;
   logic [IDX_W-1:0] free_idx;
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   logic [IDX_W-1:0] prev_idx;
   logic             prev_hit;
   assign prev_idx = idx_ff[IDX_W-1:0] - IDX_W'(1);
   assign prev_hit = valid_ff[prev_idx] && ram_rdata.msg_id == id_ff;

   logic        rsp_free;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;

   logic [63:0] elapsed;
   logic        due;
   assign elapsed = now_ff - ram_rdata.last_send;
   assign due = valid_ff[idx_ff[IDX_W-1:0]] && now_ff >= ram_rdata.last_send
                && elapsed >= {44'd0, rto};

   logic        scan_done;
   logic        emit_en;
   assign scan_done = stop_ff || idx_ff == CNT_W'(ENTRIES);

   always_comb begin
      emit_en = 1'b0;
      if (rsp_free) begin
         case (state_ff)
            S_DEC:   emit_en = 1'b1;
            S_TRD:   emit_en = scan_done;
            S_TCMP:  emit_en = due && hold_ff;
            default: emit_en = 1'b0;
         endcase
      end
   end

   always_comb begin
      ram_raddr = idx_ff[IDX_W-1:0];
      ram_we    = 1'b0;
      ram_waddr = idx_ff[IDX_W-1:0];
      ram_wdata = ram_rdata;
      if (state_ff == S_DEC && req_ff == REQ_SEND) begin
         ram_waddr = free_idx;
         ram_wdata = '{msg_id: id_ff, link: (dst_ff == {6'd0, next_p}),
                       tries: 10'd0, last_send: now_ff, hash_lo: hlo_ff, hash_hi: hhi_ff};
      end else if (state_ff == S_TCMP) begin
         ram_wdata.tries     = ram_rdata.tries + 10'd1;
         ram_wdata.last_send = now_ff;
      end
      if (state_ff == S_DEC && req_ff == REQ_SEND && id_ff != 32'd0 && !found_ff
          && (dst_ff == {6'd0, next_p} || dst_ff == {6'd0, prev_p}) && free_any) begin
         ram_we = 1'b1;
      end
      if (state_ff == S_TCMP && rsp_free && due && ram_rdata.tries < cfg_ff.max_tries) begin
         ram_we = 1'b1;
      end
   end

   task automatic emit(input logic [3:0] st, input logic [31:0] id, input logic lk,
                       input logic lst);
      rsp_status_ff <= st;
      rsp_id_ff     <= id;
      rsp_link_ff   <= lk;
      rsp_last_ff   <= lst;
   endtask

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         hold_ff  <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  req_ff   <= req_tuser;
                  id_ff    <= req_tdata[31:0];
                  dst_ff   <= req_tdata[39:32];
                  hlo_ff   <= req_tdata[103:40];
                  hhi_ff   <= req_tdata[167:104];
                  now_ff   <= req_tdata[231:168];
                  idx_ff   <= '0;
                  found_ff <= 1'b0;
                  stop_ff  <= 1'b0;
                  hold_ff  <= 1'b0;
                  found_idx_ff <= '0;
                  case (req_tuser)
                     REQ_TICK: state_ff <= S_TRD;
                     REQ_NACK: state_ff <= S_DEC;
                     default:  state_ff <= S_SRCH;
                  endcase
               end
            end
            S_SRCH: begin
               // read address idx; data of idx-1 arrives now
               if (idx_ff != '0 && prev_hit && !found_ff) begin
                  found_ff     <= 1'b1;
                  found_idx_ff <= prev_idx;
               end
               if (idx_ff == CNT_W'(ENTRIES)) begin
                  state_ff <= S_OUT;
               end else begin
                  idx_ff <= idx_ff + CNT_W'(1);
               end
            end
            S_OUT: begin
               // re-read the matched entry for ack
               idx_ff   <= CNT_W'(found_idx_ff);
               state_ff <= S_TEND;
            end
            S_TEND: begin
               state_ff <= S_DEC;
            end
            S_DEC: begin
               if (rsp_free) begin
                  state_ff <= S_IDLE;
                  case (req_ff)
                     REQ_SEND: begin
                        if (id_ff == 32'd0) emit(ST_ZERO_ID, id_ff, 1'b0, 1'b1);
                        else if (found_ff) emit(ST_DUP, id_ff, 1'b0, 1'b1);
                        else if (dst_ff != {6'd0, next_p} && dst_ff != {6'd0, prev_p})
                           emit(ST_BAD_DEST, id_ff, 1'b0, 1'b1);
                        else if (!free_any) emit(ST_FULL, id_ff, 1'b0, 1'b1);
                        else begin
                           valid_ff[free_idx] <= 1'b1;
                           emit(ST_SENT, id_ff, dst_ff == {6'd0, next_p}, 1'b1);
                        end
                     end
                     REQ_ACK: begin
                        if (dst_ff != {6'd0, cfg_ff.own_party})
                           emit(ST_ACK_NOTUS, id_ff, 1'b0, 1'b1);
                        else if (!found_ff) emit(ST_ACK_UNK, id_ff, 1'b0, 1'b1);
                        else if (ram_rdata.hash_lo != hlo_ff || ram_rdata.hash_hi != hhi_ff)
                           emit(ST_HASH_MISS, id_ff, ram_rdata.link, 1'b1);
                        else begin
                           valid_ff[found_idx_ff] <= 1'b0;
                           emit(ST_ACK_CLR, id_ff, ram_rdata.link, 1'b1);
                        end
                     end
                     default: begin
                        emit((dst_ff == {6'd0, cfg_ff.own_party}) ? ST_NACK : ST_NACK_NOTUS,
                             id_ff, 1'b0, 1'b1);
                     end
                  endcase
               end
            end
            S_TRD: begin
               if (scan_done) begin
                  if (rsp_free) begin
                     if (hold_ff) emit(hold_status_ff, hold_id_ff, hold_link_ff, 1'b1);
                     else emit(ST_NONE_DUE, 32'd0, 1'b0, 1'b1);
                     hold_ff  <= 1'b0;
                     state_ff <= S_IDLE;
                  end
               end else begin
                  state_ff <= S_TTO;   // RAM read in flight
               end
            end
            S_TTO: begin
               state_ff <= S_TCMP;     // timeout register loads
            end
            S_TCMP: begin
               if (rsp_free) begin
                  if (due) begin
                     if (hold_ff) emit(hold_status_ff, hold_id_ff, hold_link_ff, 1'b0);
                     hold_ff      <= 1'b1;
                     hold_id_ff   <= ram_rdata.msg_id;
                     hold_link_ff <= ram_rdata.link;
                     if (ram_rdata.tries >= cfg_ff.max_tries) begin
                        hold_status_ff <= ST_EXHAUST;
                        stop_ff        <= 1'b1;
                     end else begin
                        hold_status_ff <= ST_RETX;
                     end
                  end
                  idx_ff   <= idx_ff + CNT_W'(1);
                  state_ff <= S_TRD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_link_ff, rsp_id_ff, rsp_status_ff};
   assign rsp_tlast  = rsp_last_ff;
endmodule

// File: sim/retransmit_timer_table_tb.sv
`timescale 1ns / 1ps

module retransmit_timer_table_tb;
   import rtt_pkg::*;

   typedef struct packed {
      logic [3:0]  status;
      logic [31:0] msg_id;
      logic        link;
      logic        last;
   } rsp_item_type;

   // Timer table predictor plus queue of pending responses
   class timer_scoreboard;
      logic [1:0]  own_party;
      logic [15:0] base_to;
      logic [19:0] max_to;
      logic [9:0]  max_tries;
      logic        valid [ENTRIES];
      logic [31:0] ids [ENTRIES];
      logic        links [ENTRIES];
      logic [9:0]  tries [ENTRIES];
      logic [63:0] sent_at [ENTRIES];
      logic [63:0] hlo [ENTRIES];
      logic [63:0] hhi [ENTRIES];
      rsp_item_type pending[$];
      int          errors;
      int          checked;
      int          retx_seen;
      int          exhaust_seen;

      function new();
         own_party = 0;
         base_to = 50;
         max_to = 10000;
         max_tries = 400;
         errors = 0;
         checked = 0;
         retx_seen = 0;
         exhaust_seen = 0;
         foreach (valid[i]) valid[i] = 1'b0;
      endfunction

      function void write_csr(logic [1:0] idx, logic [19:0] val);
         case (idx)
            CSR_SELF:  own_party = val[1:0];
            CSR_BASE:  base_to = val[15:0];
            CSR_MAX:   max_to = val[19:0];
            CSR_TRIES: max_tries = val[9:0];
            default: ;
         endcase
      endfunction

      function void push(logic [3:0] st, logic [31:0] id, logic lk);
         rsp_item_type r;
         r.status = st;
         r.msg_id = id;
         r.link = lk;
         r.last = 1'b0;
         pending.push_back(r);
      endfunction

      function int lookup(logic [31:0] id);
         for (int i = 0; i < ENTRIES; i++)
            if (valid[i] && ids[i] == id) return i;
         return -1;
      endfunction

      function logic [63:0] backoff(logic [9:0] t);
         logic [63:0] rto;
         rto = 64'(max_to);
         if (t < 31) rto = 64'(base_to) << t;
         if (rto > 64'(max_to)) rto = 64'(max_to);
         return rto;
      endfunction

      function void note_request(logic [1:0] kind, logic [31:0] id, logic [7:0] dst,
                                 logic [63:0] h_lo, logic [63:0] h_hi,
                                 logic [63:0] now);
         logic [1:0] nxt;
         logic [1:0] prv;
         int slot;
         int n;
         int e;
         nxt = 2'((own_party + 1) % 3);
         prv = 2'((own_party + 2) % 3);
         n = pending.size();
         case (kind)
            REQ_SEND: begin
               slot = -1;
               if (id == 0) push(ST_ZERO_ID, id, 0);
               else if (lookup(id) >= 0) push(ST_DUP, id, 0);
               else if (dst != 8'(nxt) && dst != 8'(prv)) push(ST_BAD_DEST, id, 0);
               else begin
                  for (int i = 0; i < ENTRIES; i++)
                     if (!valid[i] && slot < 0) slot = i;
                  if (slot < 0) push(ST_FULL, id, 0);
                  else begin
                     valid[slot] = 1'b1;
                     ids[slot] = id;
                     links[slot] = (dst == 8'(nxt));
                     tries[slot] = 0;
                     sent_at[slot] = now;
                     hlo[slot] = h_lo;
                     hhi[slot] = h_hi;
                     push(ST_SENT, id, links[slot]);
                  end
               end
            end
            REQ_ACK: begin
               e = lookup(id);
               if (dst != 8'(own_party)) push(ST_ACK_NOTUS, id, 0);
               else if (e < 0) push(ST_ACK_UNK, id, 0);
               else if (hlo[e] != h_lo || hhi[e] != h_hi) push(ST_HASH_MISS, id, links[e]);
               else begin
                  valid[e] = 1'b0;
                  push(ST_ACK_CLR, id, links[e]);
               end
            end
            REQ_NACK: push((dst == 8'(own_party)) ? ST_NACK : ST_NACK_NOTUS, id, 0);
            default: begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (pending.size() - n >= 16) break;
                  if (!valid[i] || now < sent_at[i]) continue;
                  if (now - sent_at[i] < backoff(tries[i])) continue;
                  if (tries[i] >= max_tries) begin
                     push(ST_EXHAUST, ids[i], links[i]);
                     exhaust_seen++;
                     break;
                  end
                  push(ST_RETX, ids[i], links[i]);
                  retx_seen++;
                  tries[i] = tries[i] + 10'd1;
                  sent_at[i] = now;
               end
               if (pending.size() == n) push(ST_NONE_DUE, 0, 0);
            end
         endcase
         pending[pending.size() - 1].last = 1'b1;
      endfunction

      function void check_response(rsp_item_type got);
         rsp_item_type want;
         checked++;
         if (pending.size() == 0) begin
            $error("unexpected response status=%0d id=%h", got.status, got.msg_id);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
         end
         if (got.msg_id !== want.msg_id) begin
            $error("msg_id_res: expected %h, actual %h", want.msg_id, got.msg_id);
            errors++;
         end
         if (got.link !== want.link) begin
            $error("link: expected %0d, actual %0d", want.link, got.link);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = '0;
   logic [19:0]  csr_wdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [231:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [39:0]  rsp_tdata;
   logic         rsp_tlast;

   timer_scoreboard sb = new();
   logic [63:0] now_ms = 64'd1000;
   logic [31:0] live_ids[$];
   logic [63:0] live_hlo[$];
   logic [63:0] live_hhi[$];
   int          hold_cycles = 0;
   int          burst_left = 0;

   always #6 clock = ~clock;

   retransmit_timer_table u_top (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   // Receiver: long hold-offs when requested, otherwise own stall pattern
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_item_type r;
         r.status = rsp_tdata[3:0];
         r.msg_id = rsp_tdata[35:4];
         r.link = rsp_tdata[36];
         r.last = rsp_tlast;
         sb.check_response(r);
      end
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else if (($time / 1000) % 3 == 0) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   task automatic write_csr(logic [1:0] idx, logic [19:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_csr(idx, val);
   endtask

   task automatic wait_drained();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4 * ENTRIES + 8) @(posedge clock);
   endtask

   // Sends one transaction; caller is at a posedge. Valid stays high within a burst.
   task automatic send_req(logic [1:0] kind, logic [31:0] id, logic [7:0] dst,
                           logic [63:0] h_lo, logic [63:0] h_hi, logic [63:0] now);
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 8);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {now, h_hi, h_lo, dst, id};
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, id, dst, h_lo, h_hi, now);
      burst_left--;
      if (burst_left == 0) req_tvalid <= 1'b0;
   endtask

   task automatic idle_input();
      if (burst_left != 0) req_tvalid <= 1'b0;
      burst_left = 0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic random_item();
      int pick;
      int k;
      logic [1:0] nb;
      logic [31:0] id;
      pick = $urandom_range(0, 99);
      nb = 2'((sb.own_party + 1 + $urandom_range(0, 1)) % 3);
      now_ms = now_ms + 64'($urandom_range(0, 400));
      if (pick < 40) begin
         id = ($urandom_range(0, 9) == 0 && live_ids.size() > 0) ?
              live_ids[$urandom_range(0, live_ids.size() - 1)] : $urandom();
         if ($urandom_range(0, 19) == 0) id = 0;
         live_ids.push_back(id);
         live_hlo.push_back(rand64());
         live_hhi.push_back(rand64());
         send_req(REQ_SEND, id, ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'(nb),
                  live_hlo[$], live_hhi[$], now_ms);
      end else if (pick < 65 && live_ids.size() > 0) begin
         k = $urandom_range(0, live_ids.size() - 1);
         send_req(REQ_ACK, live_ids[k],
                  ($urandom_range(0, 7) == 0) ? 8'($urandom()) : 8'(sb.own_party),
                  live_hlo[k], ($urandom_range(0, 7) == 0) ? rand64() : live_hhi[k], now_ms);
         if (live_ids.size() > 24) begin
            live_ids.delete(0);
            live_hlo.delete(0);
            live_hhi.delete(0);
         end
      end else if (pick < 72) begin
         send_req(REQ_NACK, $urandom(),
                  ($urandom_range(0, 1) == 0) ? 8'(sb.own_party) : 8'($urandom()),
                  rand64(), rand64(), now_ms);
      end else if (pick < 75) begin
         send_req(REQ_TICK, $urandom(), 8'($urandom()), rand64(), rand64(), rand64());
      end else begin
         // tick, sometimes with the clock behind
         send_req(REQ_TICK, $urandom(), 8'($urandom()), rand64(), rand64(),
                  ($urandom_range(0, 9) == 0) ? now_ms - 5000 : now_ms);
      end
   endtask

   initial begin
      #50_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      logic [63:0] ones;
      ones = '1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset config, edge fields and every status
      send_req(REQ_TICK, 0, 0, 0, 0, 0);
      send_req(REQ_SEND, 0, 1, 0, 0, 10);
      send_req(REQ_SEND, 32'hFFFF_FFFF, 1, ones, ones, 10);
      send_req(REQ_SEND, 32'hFFFF_FFFF, 2, 0, 0, 10);
      send_req(REQ_SEND, 5, 8'hFF, 0, 0, 10);
      send_req(REQ_SEND, 5, 8'h00, 0, 0, 10);
      send_req(REQ_SEND, 6, 2, 64'h1234, 64'h5678, 20);
      send_req(REQ_ACK, 6, 8'h04, 64'h1234, 64'h5678, 20);
      send_req(REQ_ACK, 6, 0, 64'h1235, 64'h5678, 20);
      send_req(REQ_ACK, 6, 0, 64'h1234, 64'h5678, 20);
      send_req(REQ_ACK, 6, 0, 64'h1234, 64'h5678, 20);
      send_req(REQ_NACK, 9, 0, 0, 0, 20);
      send_req(REQ_NACK, 9, 8'hFF, ones, ones, 20);
      send_req(REQ_TICK, 0, 0, 0, 0, 5);
      send_req(REQ_TICK, 0, 0, 0, 0, 60);
      send_req(REQ_TICK, 0, 0, 0, 0, ones);
      for (int i = 0; i < 16; i++) send_req(REQ_SEND, 32'(100 + i), 1, 64'(i), 64'(i), 0);
      idle_input();
      // long receiver hold-off while the table answers a full tick
      hold_cycles = 400;
      send_req(REQ_TICK, 0, 0, 0, 0, ones);
      send_req(REQ_SEND, 200, 1, 0, 0, 0);
      idle_input();
      wait_drained();

      // exhaustion and tiny timeouts, party index at its top value
      write_csr(CSR_TRIES, 0);
      write_csr(CSR_BASE, 16'hFFFF);
      write_csr(CSR_MAX, 20'hFFFFF);
      write_csr(CSR_SELF, 2'd3);
      @(posedge clock);
      send_req(REQ_TICK, 0, 0, 0, 0, ones);
      send_req(REQ_NACK, 1, 3, 0, 0, 0);
      idle_input();
      wait_drained();
      write_csr(CSR_TRIES, 10'h3FF);
      write_csr(CSR_BASE, 1);
      write_csr(CSR_MAX, 1);
      write_csr(CSR_SELF, 2'd0);
      @(posedge clock);
      for (int i = 0; i < 16; i++) send_req(REQ_ACK, 32'(100 + i), 0, 64'(i), 64'(i), 0);
      idle_input();
      wait_drained();

      // random phases over several settings
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_SELF, 20'($urandom_range(0, 3)));
         write_csr(CSR_BASE, 20'((ph == 0) ? 1 : (ph == 1) ? 16'hFFFF :
                                 $urandom_range(1, 300)));
         write_csr(CSR_MAX, 20'((ph == 2) ? 20'hFFFFF : (ph == 3) ? 1 :
                                $urandom_range(1, 5000)));
         write_csr(CSR_TRIES, 20'((ph == 4) ? 0 : (ph == 5) ? 10'h3FF :
                                  $urandom_range(1, 6)));
         @(posedge clock);
         live_ids.delete();
         live_hlo.delete();
         live_hhi.delete();
         for (int n = 0; n < 48; n++) random_item();
         idle_input();
         wait_drained();
      end

      $display("Checked %0d responses; %0d retransmits and %0d exhaustions predicted.",
               sb.checked, sb.retx_seen, sb.exhaust_seen);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// File: files.f
src/rtt_pkg.sv
src/rtt_entry_ram.sv
src/rtt_timeout.sv
src/retransmit_timer_table.sv
sim/retransmit_timer_table_tb.sv
